@@ design/cbp_pkg.sv @@
// Package with the shared types, command codes and reply tables of the CAN bridge command parser.
`timescale 1ns / 1ps
`default_nettype none
package cbp_pkg;

  localparam int MaxPayloadBytes = 8;
  localparam int QueueDepth      = 2;

  localparam logic [7:0] START_BYTE = 8'hF1;

  localparam logic [7:0] CMD_BUILD_FRAME  = 8'h00;
  localparam logic [7:0] CMD_TIME_SYNC    = 8'h01;
  localparam logic [7:0] CMD_DIG_INPUTS   = 8'h02;
  localparam logic [7:0] CMD_ANA_INPUTS   = 8'h03;
  localparam logic [7:0] CMD_SET_DIG_OUT  = 8'h04;
  localparam logic [7:0] CMD_SETUP_CAN    = 8'h05;
  localparam logic [7:0] CMD_BUS_PARAMS   = 8'h06;
  localparam logic [7:0] CMD_DEV_INFO     = 8'h07;
  localparam logic [7:0] CMD_SINGLE_WIRE  = 8'h08;
  localparam logic [7:0] CMD_KEEPALIVE    = 8'h09;
  localparam logic [7:0] CMD_SYS_TYPE     = 8'h0A;
  localparam logic [7:0] CMD_NUM_BUSES    = 8'h0C;
  localparam logic [7:0] CMD_SETUP_EXT    = 8'h0D;

  localparam logic [7:0] SKIP_ONE    = 8'd1;
  localparam logic [7:0] SKIP_SETUP  = 8'd8;
  localparam logic [7:0] SKIP_EXT    = 8'd12;

  localparam logic [31:0] BAUD_WORD = 32'd500000 | 32'h8000_0000 | 32'h4000_0000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD,
    PH_ID,
    PH_BUS,
    PH_LEN,
    PH_DATA,
    PH_CHK,
    PH_SKIP
  } phase_e;

  typedef struct packed {
    logic        is_frame;
    logic [7:0]  cmd;
    logic [31:0] now_us;
    logic [28:0] id;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] payload;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [3:0] reply_len(input logic [7:0] cmd);
    logic [3:0] n;
    n = 4'd1;
    case (cmd)
      CMD_TIME_SYNC:  n = 4'd6;
      CMD_DIG_INPUTS: n = 4'd3;
      CMD_ANA_INPUTS: n = 4'd10;
      CMD_BUS_PARAMS: n = 4'd10;
      CMD_DEV_INFO:   n = 4'd7;
      CMD_KEEPALIVE:  n = 4'd4;
      CMD_NUM_BUSES:  n = 4'd3;
      default:        n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] reply_byte(input logic [7:0]  cmd,
                                            input logic [3:0]  idx,
                                            input logic [31:0] now);
    logic [7:0] r;
    r = 8'h00;
    if (idx == 4'd0) begin
      r = START_BYTE;
    end else if (idx == 4'd1) begin
      r = cmd;
    end else begin
      case (cmd)
        CMD_TIME_SYNC: begin
          case (idx)
            4'd2:    r = now[7:0];
            4'd3:    r = now[15:8];
            4'd4:    r = now[23:16];
            4'd5:    r = now[31:24];
            default: r = 8'h00;
          endcase
        end
        CMD_BUS_PARAMS: begin
          case (idx)
            4'd2:    r = BAUD_WORD[7:0];
            4'd3:    r = BAUD_WORD[15:8];
            4'd4:    r = BAUD_WORD[23:16];
            4'd5:    r = BAUD_WORD[31:24];
            default: r = 8'h00;
          endcase
        end
        CMD_DEV_INFO: begin
          case (idx)
            4'd2:    r = 8'h20;
            4'd4:    r = 8'h01;
            4'd5:    r = 8'h01;
            4'd6:    r = 8'h01;
            default: r = 8'h00;
          endcase
        end
        CMD_KEEPALIVE: begin
          case (idx)
            4'd2:    r = 8'hDE;
            4'd3:    r = 8'hAD;
            default: r = 8'h00;
          endcase
        end
        CMD_NUM_BUSES: begin
          r = (idx == 4'd2) ? 8'h01 : 8'h00;
        end
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/cbp_front.sv @@
// Front end: accepts host words, tracks the command grammar and queues reply and frame jobs.
`timescale 1ns / 1ps
`default_nettype none
module cbp_front
  import cbp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [31:0] now_us_i,
  input  wire q_stat_t     q_stat_i,
  output logic             push_o,
  output job_t             job_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [31:0] id_q, id_d;
  logic [3:0]  len_q, len_d;
  logic [63:0] buf_q, buf_d;
  logic        sniffer_q;
  logic        accept;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      id_q      <= '0;
      len_q     <= '0;
      buf_q     <= '0;
      sniffer_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      id_q    <= id_d;
      len_q   <= len_d;
      buf_q   <= buf_d;
      if (cfg_we_i) begin
        sniffer_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    id_d    = id_q;
    len_d   = len_q;
    buf_d   = buf_q;
    push_o  = 1'b0;
    job_o   = '0;
    if (accept) begin
      unique case (phase_q)
        PH_IDLE: begin
          phase_d = (rx_byte_i == START_BYTE) ? PH_CMD : PH_IDLE;
        end
        PH_CMD: begin
          phase_d = PH_IDLE;
          unique case (rx_byte_i) inside
            CMD_BUILD_FRAME: begin
              cnt_d   = '0;
              id_d    = '0;
              len_d   = '0;
              buf_d   = '0;
              phase_d = PH_ID;
            end
            CMD_TIME_SYNC, CMD_DIG_INPUTS, CMD_ANA_INPUTS, CMD_BUS_PARAMS,
            CMD_DEV_INFO, CMD_KEEPALIVE, CMD_NUM_BUSES: begin
              push_o       = 1'b1;
              job_o.cmd    = rx_byte_i;
              job_o.now_us = now_us_i;
            end
            CMD_SET_DIG_OUT, CMD_SINGLE_WIRE, CMD_SYS_TYPE: begin
              cnt_d   = SKIP_ONE;
              phase_d = PH_SKIP;
            end
            CMD_SETUP_CAN: begin
              cnt_d   = SKIP_SETUP;
              phase_d = PH_SKIP;
            end
            CMD_SETUP_EXT: begin
              cnt_d   = SKIP_EXT;
              phase_d = PH_SKIP;
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
        PH_ID: begin
          id_d  = id_q | (32'(rx_byte_i) << {cnt_q[1:0], 3'b000});
          cnt_d = cnt_q + 8'd1;
          if (cnt_d >= 8'd4) begin
            phase_d = PH_BUS;
          end
        end
        PH_BUS: begin
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (rx_byte_i > 8'(MaxPayloadBytes)) begin
            cnt_d   = rx_byte_i;
            phase_d = PH_SKIP;
          end else begin
            len_d   = rx_byte_i[3:0];
            cnt_d   = '0;
            buf_d   = '0;
            phase_d = (rx_byte_i == 8'd0) ? PH_CHK : PH_DATA;
          end
        end
        PH_DATA: begin
          buf_d = buf_q | (64'(rx_byte_i) << {cnt_q[2:0], 3'b000});
          cnt_d = cnt_q + 8'd1;
          if (cnt_d >= {4'b0000, len_q}) begin
            phase_d = PH_CHK;
          end
        end
        PH_CHK: begin
          phase_d = PH_IDLE;
          if (!sniffer_q) begin
            push_o         = 1'b1;
            job_o.is_frame = 1'b1;
            job_o.id       = id_q[28:0];
            job_o.ext      = id_q[31];
            job_o.len      = len_q;
            job_o.payload  = buf_q;
          end
        end
        PH_SKIP: begin
          if (cnt_q != 8'd0) begin
            cnt_d = cnt_q - 8'd1;
          end
          if (cnt_d == 8'd0) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/cbp_queue.sv @@
// Short job queue that decouples the parsing front end from the result back end.
`timescale 1ns / 1ps
`default_nettype none
module cbp_queue
  import cbp_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output job_t      head_o,
  output q_stat_t   stat_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CW'(Depth));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("Job pushed into a full queue.");
`endif

endmodule
`default_nettype wire

@@ design/cbp_back.sv @@
// Back end: expands queued jobs into result words and holds them in the output register.
`timescale 1ns / 1ps
`default_nettype none
module cbp_back
  import cbp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire job_t    head_i,
  input  wire q_stat_t q_stat_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output logic         kind_o,
  output logic [7:0]   reply_byte_o,
  output logic [28:0]  frame_id_o,
  output logic         frame_extended_o,
  output logic [3:0]   frame_length_o,
  output logic [63:0]  frame_payload_o,
  output logic         last_o
);

  logic        valid_q, valid_d;
  logic [3:0]  idx_q, idx_d;
  logic        load, fire, word_last;
  logic [7:0]  word_byte;

  assign load      = !valid_q || out_ready_i;
  assign fire      = load && !q_stat_i.empty;
  assign word_last = head_i.is_frame || (idx_q == reply_len(head_i.cmd) - 4'd1);
  assign word_byte = head_i.is_frame ? 8'h00 : reply_byte(head_i.cmd, idx_q, head_i.now_us);
  assign pop_o     = fire && word_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = !q_stat_i.empty;
    end
    if (fire) begin
      idx_d = word_last ? 4'd0 : idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_o           <= head_i.is_frame;
      reply_byte_o     <= word_byte;
      frame_id_o       <= head_i.is_frame ? head_i.id : '0;
      frame_extended_o <= head_i.is_frame && head_i.ext;
      frame_length_o   <= head_i.is_frame ? head_i.len : '0;
      frame_payload_o  <= head_i.is_frame ? head_i.payload : '0;
      last_o           <= word_last;
    end
  end

  assign out_valid_o = valid_q;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_stat_i.empty && !head_i.is_frame) |-> (idx_q < reply_len(head_i.cmd)))
    else $error("Reply word index ran past the reply length.");
  a_frame_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o) |-> last_o)
    else $error("Frame word not marked as last.");
  a_reply_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kind_o) |-> (frame_payload_o == '0 && frame_length_o == '0))
    else $error("Reply word carries frame fields.");
  a_idx_zero_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat_i.empty |-> (idx_q == 4'd0))
    else $error("Word index left nonzero with no job pending.");
`endif

endmodule
`default_nettype wire

@@ design/can_bridge_command_parser.sv @@
// Top level of the CAN bridge binary command parser.
// Throughput: one host word per cycle while the job queue has room; replies leave word by word.
// Input stalls only while the job queue between front and back end is full.
// Path: each job passes through the job queue and then the registered output of the back end.
// Reset: parser idle with cleared id, length and payload, queue empty, sniffer mode off.
`timescale 1ns / 1ps
`default_nettype none
module can_bridge_command_parser
  import cbp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [31:0] now_us_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       reply_byte_o,
  output logic [28:0]      frame_id_o,
  output logic             frame_extended_o,
  output logic [3:0]       frame_length_o,
  output logic [63:0]      frame_payload_o,
  output logic             last_o
);

  q_stat_t q_stat;
  job_t    push_job, head_job;
  logic    push, pop;

  cbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .now_us_i    (now_us_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  cbp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .head_o (head_job),
    .stat_o (q_stat)
  );

  cbp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_job),
    .q_stat_i         (q_stat),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .reply_byte_o     (reply_byte_o),
    .frame_id_o       (frame_id_o),
    .frame_extended_o (frame_extended_o),
    .frame_length_o   (frame_length_o),
    .frame_payload_o  (frame_payload_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

@@ bench/can_bridge_command_parser_tb.sv @@
// Testbench for the CAN bridge command parser: a directed table, then random command streams.
`timescale 1ns / 1ps
module can_bridge_command_parser_tb;
  import cbp_pkg::*;

  localparam logic [7:0]  IGNORED_BYTE = 8'hE7;
  localparam logic [7:0]  CMD_UNUSED   = 8'h0B;
  localparam logic [31:0] BAUD_REPLY   = 32'd500000 | 32'hC000_0000;
  localparam int DRAIN_CYCLES     = 16;
  localparam int QUIET_LIMIT      = 2000;
  localparam int WORDS_PER_PHASE  = 135;

  typedef enum logic [1:0] {BY_PREDICTOR, TYPED_NONE, TYPED_REPLY, TYPED_FRAME} check_e;

  typedef struct packed {
    logic [28:0] id;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] data;
  } can_frame_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  reply;
    logic [28:0] id;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] data;
    logic        last;
  } bridge_word_t;

  typedef struct {
    logic [7:0]  rx;
    logic [31:0] now;
    check_e      how;
    int          nrep;
    logic [79:0] reply;
    can_frame_t  frame;
  } host_word_t;

  localparam logic [79:0] NO_REPLY = 80'h0;
  localparam can_frame_t  NO_FRAME = '0;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic [31:0] now_us_i    = 32'h0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        kind_o;
  logic [7:0]  reply_byte_o;
  logic [28:0] frame_id_o;
  logic        frame_extended_o;
  logic [3:0]  frame_length_o;
  logic [63:0] frame_payload_o;
  logic        last_o;

  phase_e      parse_state = PH_IDLE;
  logic [7:0]  byte_count  = 8'h00;
  logic [31:0] raw_id      = 32'h0;
  logic [3:0]  frame_len   = 4'h0;
  logic [63:0] frame_data  = 64'h0;
  logic        sniffer_on  = 1'b0;

  bridge_word_t step_words[$];
  bridge_word_t awaited_words[$];
  host_word_t   host_stream[$];
  host_word_t   offered;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int           counted_words = 0;
  int           error_count   = 0;
  int           quiet_cycles  = 0;

  host_word_t directed_rows [29] = '{
    '{IGNORED_BYTE,    32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{START_BYTE,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{CMD_KEEPALIVE,   32'h0,         TYPED_REPLY, 4,  80'hF109_DEAD_0000_0000_0000, NO_FRAME},
    '{START_BYTE,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{CMD_TIME_SYNC,   32'hFFFF_FFFF, TYPED_REPLY, 6,  80'hF101_FFFF_FFFF_0000_0000, NO_FRAME},
    '{START_BYTE,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{CMD_BUS_PARAMS,  32'h0,         TYPED_REPLY, 10, 80'hF106_20A1_07C0_0000_0000, NO_FRAME},
    '{START_BYTE,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{CMD_DEV_INFO,    32'h0,         TYPED_REPLY, 7,  80'hF107_2000_0101_0100_0000, NO_FRAME},
    '{START_BYTE,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{CMD_NUM_BUSES,   32'h0,         TYPED_REPLY, 3,  80'hF10C_0100_0000_0000_0000, NO_FRAME},
    '{START_BYTE,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{CMD_DIG_INPUTS,  32'h0,         TYPED_REPLY, 3,  80'hF102_0000_0000_0000_0000, NO_FRAME},
    '{START_BYTE,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{CMD_ANA_INPUTS,  32'h0,         TYPED_REPLY, 10, 80'hF103_0000_0000_0000_0000, NO_FRAME},
    '{START_BYTE,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{CMD_UNUSED,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{START_BYTE,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{CMD_SET_DIG_OUT, 32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{START_BYTE,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{START_BYTE,      32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{CMD_BUILD_FRAME, 32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{8'hFF,           32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{8'hFF,           32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{8'hFF,           32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{8'hFF,           32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{8'h00,           32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{8'h00,           32'h0,         TYPED_NONE,  0,  NO_REPLY, NO_FRAME},
    '{IGNORED_BYTE,    32'h0,         TYPED_FRAME, 0,  NO_REPLY,
      {29'h1FFF_FFFF, 1'b1, 4'd0, 64'd0}}
  };

  can_bridge_command_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .now_us_i        (now_us_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .reply_byte_o    (reply_byte_o),
    .frame_id_o      (frame_id_o),
    .frame_extended_o(frame_extended_o),
    .frame_length_o  (frame_length_o),
    .frame_payload_o (frame_payload_o),
    .last_o          (last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic bridge_word_t make_reply(input logic [7:0] b, input logic last);
    bridge_word_t w;
    w = '0;
    w.reply = b;
    w.last = last;
    return w;
  endfunction

  function automatic bridge_word_t make_frame(input can_frame_t f);
    bridge_word_t w;
    w = '0;
    w.kind = 1'b1;
    w.id = f.id;
    w.ext = f.ext;
    w.len = f.len;
    w.data = f.data;
    w.last = 1'b1;
    return w;
  endfunction

  task automatic push_reply(input logic [79:0] msg, input int n);
    int k;
    for (k = 0; k < n; k++) begin
      step_words.push_back(make_reply(msg[79 - 8 * k -: 8], k == n - 1));
    end
  endtask

  task automatic parse_host_word(input logic [7:0] rx, input logic [31:0] now);
    logic [79:0] msg;
    int n;
    step_words.delete();
    msg = {START_BYTE, rx, 64'h0};
    n = 0;
    case (parse_state)
      PH_CMD: begin
        parse_state = PH_IDLE;
        case (rx)
          CMD_BUILD_FRAME: begin
            byte_count = 8'h00;
            raw_id = 32'h0;
            frame_len = 4'h0;
            frame_data = 64'h0;
            parse_state = PH_ID;
          end
          CMD_TIME_SYNC: begin
            msg[63:32] = {now[7:0], now[15:8], now[23:16], now[31:24]};
            n = 6;
          end
          CMD_DIG_INPUTS: n = 3;
          CMD_ANA_INPUTS: n = 10;
          CMD_BUS_PARAMS: begin
            msg[63:32] = {BAUD_REPLY[7:0], BAUD_REPLY[15:8], BAUD_REPLY[23:16],
                          BAUD_REPLY[31:24]};
            n = 10;
          end
          CMD_DEV_INFO: begin
            msg[63:24] = 40'h20_0001_0101;
            n = 7;
          end
          CMD_KEEPALIVE: begin
            msg[63:48] = 16'hDEAD;
            n = 4;
          end
          CMD_NUM_BUSES: begin
            msg[63:56] = 8'h01;
            n = 3;
          end
          CMD_SET_DIG_OUT, CMD_SINGLE_WIRE, CMD_SYS_TYPE: begin
            byte_count = SKIP_ONE;
            parse_state = PH_SKIP;
          end
          CMD_SETUP_CAN: begin
            byte_count = SKIP_SETUP;
            parse_state = PH_SKIP;
          end
          CMD_SETUP_EXT: begin
            byte_count = SKIP_EXT;
            parse_state = PH_SKIP;
          end
          default: ;
        endcase
      end
      PH_ID: begin
        raw_id[{byte_count[1:0], 3'b000} +: 8] = rx;
        byte_count = byte_count + 8'd1;
        if (byte_count >= 8'd4) parse_state = PH_BUS;
      end
      PH_BUS: parse_state = PH_LEN;
      PH_LEN: begin
        if (rx > MaxPayloadBytes) begin
          byte_count = rx;
          parse_state = PH_SKIP;
        end else begin
          frame_len = rx[3:0];
          byte_count = 8'h00;
          frame_data = 64'h0;
          parse_state = (rx == 8'h00) ? PH_CHK : PH_DATA;
        end
      end
      PH_DATA: begin
        frame_data[{byte_count[2:0], 3'b000} +: 8] = rx;
        byte_count = byte_count + 8'd1;
        if (byte_count >= frame_len) parse_state = PH_CHK;
      end
      PH_CHK: begin
        parse_state = PH_IDLE;
        if (!sniffer_on) begin
          step_words.push_back(make_frame({raw_id[28:0], raw_id[31], frame_len, frame_data}));
        end
      end
      PH_SKIP: begin
        if (byte_count > 8'h00) byte_count = byte_count - 8'd1;
        if (byte_count == 8'h00) parse_state = PH_IDLE;
      end
      default: parse_state = (rx == START_BYTE) ? PH_CMD : PH_IDLE;
    endcase
    push_reply(msg, n);
  endtask

  task automatic take_host_word(input host_word_t w);
    parse_host_word(w.rx, w.now);
    if (w.how != BY_PREDICTOR) begin
      step_words.delete();
      if (w.how == TYPED_REPLY) push_reply(w.reply, w.nrep);
      if (w.how == TYPED_FRAME) step_words.push_back(make_frame(w.frame));
    end
    foreach (step_words[i]) awaited_words.push_back(step_words[i]);
  endtask

  task automatic flag_error(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result_word();
    bridge_word_t got;
    bridge_word_t want;
    got = {kind_o, reply_byte_o, frame_id_o, frame_extended_o, frame_length_o,
           frame_payload_o, last_o};
    if (awaited_words.size() == 0) begin
      flag_error($sformatf("result word %0h arrived with nothing expected", got));
    end else begin
      want = awaited_words.pop_front();
      compare_field("kind", 64'(got.kind), 64'(want.kind));
      compare_field("reply_byte", 64'(got.reply), 64'(want.reply));
      compare_field("frame_id", 64'(got.id), 64'(want.id));
      compare_field("frame_extended", 64'(got.ext), 64'(want.ext));
      compare_field("frame_length", 64'(got.len), 64'(want.len));
      compare_field("frame_payload", got.data, want.data);
      compare_field("last", 64'(got.last), 64'(want.last));
    end
  endtask

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) take_host_word(offered);
    if (out_valid_o && out_ready_i) check_result_word();
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[can_bridge_command_parser] ERROR");
      $finish;
    end
  end

  task automatic send_word(input host_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    offered = w;
    rx_byte_i = w.rx;
    now_us_i = w.now;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (awaited_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_sniffer(input logic mode);
    cfg_we_i = 1'b1;
    cfg_wdata_i = mode;
    sniffer_on = mode;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [7:0] random_byte();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return START_BYTE;
    if (r == 1) return IGNORED_BYTE;
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_byte(input logic [7:0] rx, input bit counts);
    host_word_t w;
    w.rx = rx;
    w.now = $urandom;
    w.how = BY_PREDICTOR;
    w.nrep = 0;
    w.reply = NO_REPLY;
    w.frame = NO_FRAME;
    host_stream.push_back(w);
    if (counts) counted_words++;
  endtask

  task automatic queue_random_command();
    int unsigned pick;
    int unsigned len;
    logic [7:0] cmd;
    pick = $urandom_range(99);
    if (pick < 35) begin
      queue_byte(START_BYTE, 1);
      queue_byte(CMD_BUILD_FRAME, 1);
      repeat (5) queue_byte(random_byte(), 1);
      if ($urandom_range(4) != 0) len = $urandom_range(MaxPayloadBytes);
      else if ($urandom_range(15) == 0) len = 255;
      else len = $urandom_range(20, MaxPayloadBytes + 1);
      queue_byte(len[7:0], 1);
      repeat (len) queue_byte(random_byte(), 1);
      if (len <= MaxPayloadBytes) queue_byte(random_byte(), 1);
    end else if (pick < 70) begin
      case ($urandom_range(6))
        0: cmd = CMD_TIME_SYNC;
        1: cmd = CMD_DIG_INPUTS;
        2: cmd = CMD_ANA_INPUTS;
        3: cmd = CMD_BUS_PARAMS;
        4: cmd = CMD_DEV_INFO;
        5: cmd = CMD_KEEPALIVE;
        default: cmd = CMD_NUM_BUSES;
      endcase
      queue_byte(START_BYTE, 1);
      queue_byte(cmd, 1);
    end else if (pick < 85) begin
      case ($urandom_range(4))
        0: begin cmd = CMD_SET_DIG_OUT; len = SKIP_ONE; end
        1: begin cmd = CMD_SINGLE_WIRE; len = SKIP_ONE; end
        2: begin cmd = CMD_SYS_TYPE; len = SKIP_ONE; end
        3: begin cmd = CMD_SETUP_CAN; len = SKIP_SETUP; end
        default: begin cmd = CMD_SETUP_EXT; len = SKIP_EXT; end
      endcase
      queue_byte(START_BYTE, 1);
      queue_byte(cmd, 1);
      repeat (len) queue_byte(random_byte(), 1);
    end else if (pick < 92) begin
      if ($urandom_range(3) == 0) cmd = CMD_UNUSED;
      else cmd = 8'($urandom_range(255, CMD_SETUP_EXT + 1));
      queue_byte(START_BYTE, 1);
      queue_byte(cmd, 1);
    end else begin
      repeat ($urandom_range(3, 1)) queue_byte(random_byte(), 0);
    end
  endtask

  task automatic run_random_phase();
    host_word_t filler;
    host_stream.delete();
    counted_words = 0;
    while (counted_words < WORDS_PER_PHASE) queue_random_command();
    foreach (host_stream[i]) send_word(host_stream[i]);
    filler = '{8'h00, 32'h0, BY_PREDICTOR, 0, NO_REPLY, NO_FRAME};
    while (parse_state != PH_IDLE) begin
      filler.rx = (parse_state == PH_CMD) ? CMD_UNUSED : 8'h00;
      filler.now = $urandom;
      send_word(filler);
    end
  endtask

  initial begin
    int p;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_idle_pct = 16;
    recv_idle_pct = 72;
    write_sniffer(1'b0);
    foreach (directed_rows[i]) send_word(directed_rows[i]);
    settle();
    for (p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 16 : (p == 1) ? 72 : 0;
      recv_idle_pct = (p == 0) ? 72 : (p == 1) ? 16 : 0;
      write_sniffer(p == 1);
      run_random_phase();
      settle();
    end
    if (error_count == 0) begin
      $display("[can_bridge_command_parser] OK");
    end else begin
      $display("[can_bridge_command_parser] ERROR");
    end
    $finish;
  end

endmodule
